// ----- hw/rtl/assert_macros.svh -----
// ------------------------------------------------------------------------
// assertion macros
// clocked implication checks used by the checker file uart_chk
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/uart_pkg.sv -----
// ------------------------------------------------------------------------
// uart_pkg
// shared constants and beat types of the 8n1 oversampled uart
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package uart_pkg;

  localparam int FIFO_DEPTH     = 16;
  localparam int PTR_W          = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W          = $clog2(FIFO_DEPTH + 1);
  localparam int TICKS_PER_BIT  = 4;
  localparam int PHASE_W        = $clog2(TICKS_PER_BIT);
  localparam int RX_START_PHASE = TICKS_PER_BIT / 2;
  localparam int STOP_BIT       = 9;
  localparam int BIT_CNT_W      = 4;

  typedef struct packed {
    logic       rx_line;
    logic       tx_load;
    logic [7:0] tx_byte;
    logic       rx_pop;
  } tick_in_t;

  typedef struct packed {
    logic       tx_line;
    logic       tx_busy;
    logic       rx_ready;
    logic [7:0] rx_data;
    logic       rx_overrun;
  } tick_out_t;

  typedef struct packed {
    logic line;
    logic busy;
  } tx_status_t;

  typedef struct packed {
    logic       done;
    logic [7:0] data;
  } rx_push_t;

  typedef struct packed {
    logic       ready;
    logic [7:0] head;
    logic       overrun;
  } fifo_status_t;

endpackage

// ----- hw/rtl/uart_in_if.sv -----
// ------------------------------------------------------------------------
// uart_in_if
// valid/ready channel carrying one tick beat into the uart
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

interface uart_in_if;
  logic               valid;
  logic               ready;
  uart_pkg::tick_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/uart_out_if.sv -----
// ------------------------------------------------------------------------
// uart_out_if
// valid/ready channel carrying one result beat out of the uart
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

interface uart_out_if;
  logic                valid;
  logic                ready;
  uart_pkg::tick_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/uart_tx.sv -----
// ------------------------------------------------------------------------
// uart_tx
// 8n1 transmitter, one bit every TICKS_PER_BIT ticks
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_tx (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  uart_pkg::tick_in_t   tick,
  output uart_pkg::tx_status_t status
);

  logic                           active, active_next;
  logic [uart_pkg::PHASE_W-1:0]   phase, phase_next;
  logic [uart_pkg::BIT_CNT_W-1:0] bit_count, bit_count_next;
  logic [7:0]                     shift, shift_next;
  logic                           level, level_next;

  always_comb begin
    active_next    = active;
    phase_next     = phase;
    bit_count_next = bit_count;
    shift_next     = shift;
    level_next     = level;
    if (active) begin
      if (phase == uart_pkg::PHASE_W'(uart_pkg::TICKS_PER_BIT - 1)) begin
        phase_next = '0;
        if (bit_count == '0) begin
          // start bit
          level_next     = 1'b0;
          bit_count_next = uart_pkg::BIT_CNT_W'(1);
        end else if (bit_count < uart_pkg::BIT_CNT_W'(uart_pkg::STOP_BIT)) begin
          level_next     = shift[0];
          shift_next     = {1'b0, shift[7:1]};
          bit_count_next = bit_count + uart_pkg::BIT_CNT_W'(1);
        end else begin
          // stop bit, character done
          level_next     = 1'b1;
          bit_count_next = '0;
          active_next    = 1'b0;
        end
      end else begin
        phase_next = phase + uart_pkg::PHASE_W'(1);
      end
    end
    // load is taken while idle or on the tick the stop bit starts
    if (tick.tx_load && !active_next) begin
      shift_next     = tick.tx_byte;
      active_next    = 1'b1;
      phase_next     = '0;
      bit_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      phase     <= '0;
      bit_count <= '0;
      shift     <= '0;
      level     <= 1'b1;
    end else if (en) begin
      active    <= active_next;
      phase     <= phase_next;
      bit_count <= bit_count_next;
      shift     <= shift_next;
      level     <= level_next;
    end
  end

  assign status.line = level_next;
  assign status.busy = active_next;

endmodule

// ----- hw/rtl/uart_rx.sv -----
// ------------------------------------------------------------------------
// uart_rx
// 8n1 receiver with mid-bit start check
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_rx (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  uart_pkg::tick_in_t tick,
  output uart_pkg::rx_push_t push
);

  logic                           active, active_next;
  logic [uart_pkg::PHASE_W-1:0]   phase, phase_next;
  logic [uart_pkg::BIT_CNT_W-1:0] bit_count, bit_count_next;
  logic [7:0]                     shift, shift_next;
  logic [2:0]                     bit_idx;
  logic                           done;

  assign bit_idx = 3'(bit_count - uart_pkg::BIT_CNT_W'(1));

  always_comb begin
    active_next    = active;
    phase_next     = phase;
    bit_count_next = bit_count;
    shift_next     = shift;
    done           = 1'b0;
    if (!active) begin
      if (!tick.rx_line) begin
        phase_next     = uart_pkg::PHASE_W'(uart_pkg::RX_START_PHASE);
        active_next    = 1'b1;
        bit_count_next = '0;
      end
    end else if (phase == uart_pkg::PHASE_W'(uart_pkg::TICKS_PER_BIT - 1)) begin
      phase_next = '0;
      if (bit_count == '0) begin
        if (!tick.rx_line) begin
          bit_count_next = uart_pkg::BIT_CNT_W'(1);
          shift_next     = '0;
        end else begin
          // false start
          active_next = 1'b0;
        end
      end else if (bit_count < uart_pkg::BIT_CNT_W'(uart_pkg::STOP_BIT)) begin
        if (tick.rx_line) begin
          shift_next[bit_idx] = 1'b1;
        end
        bit_count_next = bit_count + uart_pkg::BIT_CNT_W'(1);
      end else if (bit_count == uart_pkg::BIT_CNT_W'(uart_pkg::STOP_BIT)) begin
        bit_count_next = bit_count + uart_pkg::BIT_CNT_W'(1);
      end else begin
        active_next = 1'b0;
        done        = 1'b1;
      end
    end else begin
      phase_next = phase + uart_pkg::PHASE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      phase     <= '0;
      bit_count <= '0;
      shift     <= '0;
    end else if (en) begin
      active    <= active_next;
      phase     <= phase_next;
      bit_count <= bit_count_next;
      shift     <= shift_next;
    end
  end

  assign push.done = done;
  assign push.data = shift;

endmodule

// ----- hw/rtl/uart_fifo.sv -----
// ------------------------------------------------------------------------
// uart_fifo
// receive fifo, pop before push, drops a byte when still full
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   pop,
  input  uart_pkg::rx_push_t     push,
  output uart_pkg::fifo_status_t status
);

  logic [7:0]                 mem [uart_pkg::FIFO_DEPTH];
  logic [7:0]                 head;
  logic [uart_pkg::PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [uart_pkg::PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [uart_pkg::CNT_W-1:0] count, count_next;
  logic                       ready;
  logic                       do_pop;
  logic                       do_push;
  logic                       full_after_pop;

  assign ready          = (count != '0);
  assign do_pop         = pop && ready;
  assign full_after_pop = (count == uart_pkg::CNT_W'(uart_pkg::FIFO_DEPTH)) && !do_pop;
  assign do_push        = push.done && !full_after_pop;

  always_comb begin
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    count_next  = count;
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == uart_pkg::PTR_W'(uart_pkg::FIFO_DEPTH - 1)) ?
                    '0 : rd_ptr + uart_pkg::PTR_W'(1);
    end
    if (do_push) begin
      wr_ptr_next = (wr_ptr == uart_pkg::PTR_W'(uart_pkg::FIFO_DEPTH - 1)) ?
                    '0 : wr_ptr + uart_pkg::PTR_W'(1);
    end
    case ({do_pop, do_push})
      2'b10:   count_next = count - uart_pkg::CNT_W'(1);
      2'b01:   count_next = count + uart_pkg::CNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else if (en) begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // head register follows the next read address, bypassing a write to it
  always_ff @(posedge clk) begin
    if (en) begin
      if (do_push) begin
        mem[wr_ptr] <= push.data;
      end
      if (do_push && (wr_ptr == rd_ptr_next)) begin
        head <= push.data;
      end else begin
        head <= mem[rd_ptr_next];
      end
    end
  end

  assign status.ready   = ready;
  assign status.head    = ready ? head : 8'h00;
  assign status.overrun = push.done && full_after_pop;

endmodule

// ----- hw/rtl/uart_8n1_oversampled_txrx.sv -----
// ------------------------------------------------------------------------
// uart_8n1_oversampled_txrx
// single 8n1 uart port, four oversampling ticks per bit, with rx fifo
// ------------------------------------------------------------------------
//
//   channel   dir  beat fields                                 per beat
//   tick_in   in   rx_line, tx_load, tx_byte, rx_pop           one tick
//   tick_out  out  tx_line, tx_busy, rx_ready, rx_data,        one result
//                  rx_overrun
//
// one tick beat in, one result beat out, one beat per cycle while tick_out is not stalled
// the tick beat is registered at the input; state and result are updated
// together into the result register once the result slot is free
// rst is synchronous; it returns the line to idle high and empties the fifo
// a stalled tick_out holds its beat and the tick register; tick_in takes a
// new beat whenever the tick register is free or moves on the same edge
//
`timescale 1ns / 1ps

module uart_8n1_oversampled_txrx (
  input  logic        clk,
  input  logic        rst,
  uart_in_if.sink     tick_in,
  uart_out_if.source  tick_out
);

  // input register
  logic                   in_valid;
  uart_pkg::tick_in_t     in_tick;

  // result register
  logic                   out_valid;
  uart_pkg::tick_out_t    out_beat;

  logic                   advance;
  uart_pkg::tx_status_t   tx_status;
  uart_pkg::rx_push_t     rx_push;
  uart_pkg::fifo_status_t fifo_status;
  uart_pkg::tick_out_t    result;

  // the tick in the input register is processed once the result slot frees
  assign advance       = in_valid && (!out_valid || tick_out.ready);
  assign tick_in.ready = !in_valid || advance;

  uart_tx u_tx (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .tick   (in_tick),
    .status (tx_status)
  );

  uart_rx u_rx (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .tick (in_tick),
    .push (rx_push)
  );

  // pop acts before the push of the same tick
  uart_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .pop    (in_tick.rx_pop),
    .push   (rx_push),
    .status (fifo_status)
  );

  always_comb begin
    result.tx_line    = tx_status.line;
    result.tx_busy    = tx_status.busy;
    result.rx_ready   = fifo_status.ready;
    result.rx_data    = fifo_status.head;
    result.rx_overrun = fifo_status.overrun;
  end

  // handshake control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (tick_in.ready) begin
        in_valid <= tick_in.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (tick_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // beat payloads
  always_ff @(posedge clk) begin
    if (tick_in.valid && tick_in.ready) begin
      in_tick <= tick_in.payload;
    end
    if (advance) begin
      out_beat <= result;
    end
  end

  assign tick_out.valid   = out_valid;
  assign tick_out.payload = out_beat;

endmodule

// ----- hw/rtl/uart_chk.sv -----
// ------------------------------------------------------------------------
// uart_chk
// port-level checks on the uart result channel
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uart_chk (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input uart_pkg::tick_out_t out_beat
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_beat), "result beat changed while stalled")
  `ASSERT_IMPL(a_empty_data, clk, rst, out_valid && !out_beat.rx_ready, out_beat.rx_data == 8'h00, "rx_data nonzero with empty fifo")
  `ASSERT_IMPL(a_idle_line, clk, rst, out_valid && !out_beat.tx_busy, out_beat.tx_line, "tx line low while transmitter idle")
  `ASSERT_IMPL(a_overrun_full, clk, rst, out_valid && out_beat.rx_overrun, out_beat.rx_ready, "overrun flagged with empty fifo")

endmodule

bind uart_8n1_oversampled_txrx uart_chk u_uart_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (tick_out.valid),
  .out_ready (tick_out.ready),
  .out_beat  (tick_out.payload)
);
